### rtl/vector_block_average_decimator_macros.svh
// ----------------------------------------------------------------------------
// vector block average decimator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef VECTOR_BLOCK_AVERAGE_DECIMATOR_MACROS_SVH
`define VECTOR_BLOCK_AVERAGE_DECIMATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define VBAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VBAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vbad_pkg.sv
// ----------------------------------------------------------------------------
// vbad_pkg
// shared types and constants of the vector block average decimator
// ----------------------------------------------------------------------------
`default_nettype none

package vbad_pkg;

    // default sizing
    localparam int DEF_MAX_VEC_LEN = 1024;
    localparam int DEF_MAX_AVG     = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration register file
    localparam int VEC_LEN_W   = 11;
    localparam int AVG_COUNT_W = 9;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT = 1'd1;

    localparam logic [VEC_LEN_W-1:0]   VEC_LEN_RST   = 11'd1024;
    localparam logic [AVG_COUNT_W-1:0] AVG_COUNT_RST = 9'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

### rtl/vbad_ram.sv
// ----------------------------------------------------------------------------
// vbad_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module vbad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/vbad_div.sv
// ----------------------------------------------------------------------------
// vbad_div
// signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module vbad_div
    import vbad_pkg::*;
#(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 9
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [DIVIDEND_W-1:0] dividend,
    input  wire logic        [DIVISOR_W-1:0]  divisor,
    output logic signed      [DIVIDEND_W-1:0] quotient,
    output div_status_t                       status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic                  neg_reg;
    logic signed [DIVIDEND_W-1:0] quotient_reg;

    logic [DIVIDEND_W-1:0] magnitude;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_step;
    logic [DIVIDEND_W-1:0] quo_step;

    assign magnitude = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

    // bring down the next dividend bit and try the subtract
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_step = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    assign quo_step = {quo_reg[DIVIDEND_W-2:0], ge};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[DIVIDEND_W-1];
        end else if (busy_reg) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
            if (cnt_reg == CNT_W'(1)) begin
                quotient_reg <= neg_reg ? DIVIDEND_W'(-quo_step) : DIVIDEND_W'(quo_step);
            end
        end
    end

    assign quotient    = quotient_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### rtl/vector_block_average_decimator.sv
// Vector integrate-and-dump averager. Samples arrive as vectors of vec_len
// elements; each group of avg_count vectors is summed element by element in
// an accumulator ram (first vector of a group overwrites, later ones add),
// and during the last vector of a group every element leaves as sum /
// avg_count truncated toward zero, with m_last_element on the vector's final
// element. One sample is in flight at a time. A sample that yields no result
// takes a ram read, then an add and write back. With avg_count = 1 the sample
// then also passes through the emit state. On the last vector of a group with
// avg_count > 1 the sum goes through a one-bit-per-cycle divider as wide as the
// accumulator before the emit state, and the emit waits while the output
// register is held by m_ready. Configuration writes take effect at once and
// belong between transfers when the block is idle.

`default_nettype none

module vector_block_average_decimator
    import vbad_pkg::*;
#(
    parameter int MAX_VEC_LEN = DEF_MAX_VEC_LEN,
    parameter int MAX_AVG     = DEF_MAX_AVG,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_wdata,
    // sample stream
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    // averaged stream
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_average,
    output logic                               m_last_element
);

    localparam int IDX_W  = (MAX_VEC_LEN > 1) ? $clog2(MAX_VEC_LEN) : 1;
    localparam int VIDX_W = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
    localparam int LEN_W  = $clog2(MAX_VEC_LEN + 1);
    localparam int AVG_W  = $clog2(MAX_AVG + 1);
    localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_AVG);

    // configuration registers
    logic [VEC_LEN_W-1:0]   vec_len_reg;
    logic [AVG_COUNT_W-1:0] avg_count_reg;

    // control
    state_t state_reg, state_next;
    logic [IDX_W-1:0]  elem_idx_reg;
    logic [VIDX_W-1:0] vec_idx_reg;

    // captured sample
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [IDX_W-1:0]              addr_reg;
    logic                          first_reg;
    logic                          last_elem_reg;
    logic                          last_vec_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;

    // output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_average_reg;
    logic                          m_last_reg;

    logic [LEN_W-1:0] eff_len;
    logic [AVG_W-1:0] eff_avg;
    logic             accept;
    logic             last_elem;
    logic             last_vec;
    logic             avg_one;
    logic             out_free;
    logic             ram_we;
    logic             div_start;

    logic [ACC_W-1:0]        rd_data;
    logic signed [ACC_W-1:0] acc_old;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] quotient;
    div_status_t             div_status;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_len_reg   <= VEC_LEN_RST;
            avg_count_reg <= AVG_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VEC_LEN:   vec_len_reg   <= cfg_wdata[VEC_LEN_W-1:0];
                REG_AVG_COUNT: avg_count_reg <= cfg_wdata[AVG_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range register values saturate
    always_comb begin
        if (vec_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(vec_len_reg) > MAX_VEC_LEN) begin
            eff_len = LEN_W'(MAX_VEC_LEN);
        end else begin
            eff_len = LEN_W'(vec_len_reg);
        end
        if (avg_count_reg == '0) begin
            eff_avg = AVG_W'(1);
        end else if (32'(avg_count_reg) > MAX_AVG) begin
            eff_avg = AVG_W'(MAX_AVG);
        end else begin
            eff_avg = AVG_W'(avg_count_reg);
        end
    end

    assign accept    = s_valid && s_ready;
    assign last_elem = (32'(elem_idx_reg) + 32'd1) >= 32'(eff_len);
    assign last_vec  = (32'(vec_idx_reg) + 32'd1) >= 32'(eff_avg);
    assign avg_one   = (eff_avg == AVG_W'(1));
    assign out_free  = !m_valid_reg || m_ready;

    assign acc_old = rd_data;
    assign sum     = first_reg ? ACC_W'(sample_reg) : acc_old + ACC_W'(sample_reg);

    assign ram_we    = (state_reg == ST_RMW);
    assign div_start = (state_reg == ST_RMW) && last_vec_reg && !avg_one;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                if (!last_vec_reg) begin
                    state_next = ST_IDLE;
                end else if (avg_one) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // element and vector counters advance on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_idx_reg <= '0;
            vec_idx_reg  <= '0;
        end else if (accept) begin
            if (last_elem) begin
                elem_idx_reg <= '0;
                vec_idx_reg  <= last_vec ? '0 : vec_idx_reg + VIDX_W'(1);
            end else begin
                elem_idx_reg <= elem_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg    <= s_sample;
            addr_reg      <= elem_idx_reg;
            first_reg     <= (vec_idx_reg == '0);
            last_elem_reg <= last_elem;
            last_vec_reg  <= last_vec;
        end
        if (state_reg == ST_RMW) begin
            res_reg <= sum[SAMPLE_BITS-1:0];
        end else if (state_reg == ST_DIV && div_status.done) begin
            res_reg <= quotient[SAMPLE_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_average_reg <= res_reg;
            m_last_reg    <= last_elem_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_average      = m_average_reg;
    assign m_last_element = m_last_reg;

    vbad_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_VEC_LEN)
    ) u_accum_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (sum),
        .rd_en   (accept),
        .rd_addr (elem_idx_reg),
        .rd_data (rd_data)
    );

    vbad_div #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (AVG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum),
        .divisor  (eff_avg),
        .quotient (quotient),
        .status   (div_status)
    );

endmodule

`default_nettype wire

### rtl/vbad_checker.sv
// ----------------------------------------------------------------------------
// vbad_port_checker
// port-level checks of the vector block average decimator, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_block_average_decimator_macros.svh"

module vbad_port_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [SAMPLE_BITS-1:0] m_average,
    input wire logic                   m_last_element
);

    logic                 out_stall;
    logic [SAMPLE_BITS:0] out_payload;

    assign out_stall   = m_valid && !m_ready;
    assign out_payload = {m_average, m_last_element};

    // a stalled result keeps its payload
    `VBAD_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(out_payload), "held result changed")

    // one sample in flight: no input transfer right after another
    `VBAD_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "input taken while busy")

    // a new result is only loaded while the input side is closed
    `VBAD_ASSERT_NOW(a_emit_closed, $rose(m_valid), !$past(s_ready), "result loaded while idle")

endmodule

bind vector_block_average_decimator vbad_port_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_vbad_port_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_average      (m_average),
    .m_last_element (m_last_element)
);

`default_nettype wire
